/* hw/rtl/gcgm_pkg.sv */
// Shared types, constants and helpers for the gray-to-color gradient map.
`default_nettype none

package gcgm_pkg;

  localparam int PIX_W     = 8;   // pixel, level and color component width
  localparam int CFG_W     = 64;  // widest configuration register
  localparam int CFG_IDX_W = 3;   // configuration register index width
  localparam int SLOT_W    = 3;   // index of a byte lane in a packed register
  localparam int NCH       = 3;   // red, green, blue
  localparam int DIV_STEPS = PIX_W;  // one quotient bit per divider stage
  localparam int PIPE_LAT  = 3 + DIV_STEPS;  // accept edge to strobe cycle

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_STOP_COUNT = 3'd1,
    CFG_LEVELS     = 3'd2,
    CFG_RED        = 3'd3,
    CFG_GREEN      = 3'd4,
    CFG_BLUE       = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    MODE_GRADIENT = 1'b0,
    MODE_CUT      = 1'b1
  } mode_t;

  // Byte lane idx of a packed eight-stop register.
  function automatic logic [PIX_W-1:0] byte_of(input logic [CFG_W-1:0] pk,
                                               input logic [SLOT_W-1:0] idx);
    return pk[{idx, 3'b000} +: PIX_W];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gray_to_color_gradient_map.sv */
// Top level: pipelined gray-to-color gradient map.
//
// Usage
//   Input: a transaction is accepted at a rising edge with start high and
//   busy low. busy stays low: the pipeline takes a new pixel every cycle.
//   Output: out_valid marks one cycle carrying out_red/out_green/out_blue.
//   The receiver cannot stall, so nothing in the pipeline ever holds.
//   Config: cfg_we/cfg_index/cfg_data write one register per edge; write
//   only while no pixel is in flight.
// Pipeline / throughput
//   out_valid follows the accepting edge through the registered stages search,
//   select, multiply, then eight divider stages of one quotient bit each.
//   Throughput is one pixel per clock; results leave in input order.
// Reset
//   rst_n low (synchronous) clears all valid bits and restores the default
//   map: two stops, level 0 black to level 255 white, gradient mode.
`default_nettype none

module gray_to_color_gradient_map
  import gcgm_pkg::*;
#(
  parameter int MAX_STOPS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PIX_W-1:0]     in_gray_level,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      out_valid,
  output logic [PIX_W-1:0]          out_red,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_blue
);

  // Stop index width: must hold MAX_STOPS itself ("past the last stop").
  localparam int KW = $clog2(MAX_STOPS + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  mode_t          mode_r;
  logic [3:0]     stop_count_r;
  logic [CFG_W-1:0] levels_r;
  logic [CFG_W-1:0] red_r;
  logic [CFG_W-1:0] green_r;
  logic [CFG_W-1:0] blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_GRADIENT;
      stop_count_r <= 4'd2;
      levels_r     <= CFG_W'(16'hFF00);
      red_r        <= CFG_W'(16'hFF00);
      green_r      <= CFG_W'(16'hFF00);
      blue_r       <= CFG_W'(16'hFF00);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:       mode_r       <= mode_t'(cfg_data[0]);
        CFG_STOP_COUNT: stop_count_r <= cfg_data[3:0];
        CFG_LEVELS:     levels_r     <= cfg_data;
        CFG_RED:        red_r        <= cfg_data;
        CFG_GREEN:      green_r      <= cfg_data;
        CFG_BLUE:       blue_r       <= cfg_data;
        default:        ;  // unmapped index: write dropped
      endcase
    end
  end

  // Every cycle can take a transaction.
  assign busy = 1'b0;

  logic in_take;
  assign in_take = start && !busy;

  // ---------------------------------------------------------------------
  // Stage 1: stop search (parallel compares, lowest index wins)
  // ---------------------------------------------------------------------
  logic [KW-1:0]     n_w;
  logic [KW-1:0]     k_w;
  logic              past_end_w;
  logic              flat_w;
  logic [SLOT_W-1:0] lo_idx_w;

  always_comb begin
    if (stop_count_r > 4'(MAX_STOPS)) begin
      n_w = KW'(MAX_STOPS);
    end else if (stop_count_r == 4'd0) begin
      n_w = KW'(1);
    end else begin
      n_w = KW'(stop_count_r);
    end
    k_w = n_w;
    for (int i = MAX_STOPS - 1; i >= 1; i--) begin
      if ((KW'(i) < n_w) && (in_gray_level <= byte_of(levels_r, SLOT_W'(i)))) begin
        k_w = KW'(i);
      end
    end
    past_end_w = (k_w >= n_w);
    flat_w     = past_end_w || (mode_r == MODE_CUT);
    lo_idx_w   = past_end_w ? SLOT_W'(n_w - KW'(1)) : SLOT_W'(k_w - KW'(1));
  end

  logic              s1_v_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              s1_flat_r;
  logic [SLOT_W-1:0] s1_lo_idx_r;
  logic [SLOT_W-1:0] s1_hi_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r    <= in_gray_level;
    s1_flat_r   <= flat_w;
    s1_lo_idx_r <= lo_idx_w;
    s1_hi_idx_r <= SLOT_W'(k_w);
  end

  // ---------------------------------------------------------------------
  // Stage 2: pick the two stops, form gap d and offset a.
  // Flat color and zero gap both become lo*1 + hi*0 over d = 1.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] pal_w [NCH];
  logic [PIX_W-1:0] lo_lvl_w, hi_lvl_w, d_w, a_w;
  logic [PIX_W-1:0] d_fix_w, a_fix_w;
  logic [PIX_W-1:0] lo_c_w [NCH];
  logic [PIX_W-1:0] hi_c_w [NCH];

  assign pal_w[0] = red_r;
  assign pal_w[1] = green_r;
  assign pal_w[2] = blue_r;

  always_comb begin
    lo_lvl_w = byte_of(levels_r, s1_lo_idx_r);
    hi_lvl_w = byte_of(levels_r, s1_hi_idx_r);
    d_w      = hi_lvl_w - lo_lvl_w;   // 8-bit wrapping gap
    a_w      = s1_pix_r - lo_lvl_w;   // 8-bit wrapping offset
    if (a_w > d_w) begin
      a_w = d_w;
    end
    if (s1_flat_r || (d_w == '0)) begin
      d_fix_w = PIX_W'(1);
      a_fix_w = '0;
    end else begin
      d_fix_w = d_w;
      a_fix_w = a_w;
    end
    for (int c = 0; c < NCH; c++) begin
      lo_c_w[c] = byte_of(pal_w[c], s1_lo_idx_r);
      hi_c_w[c] = byte_of(pal_w[c], s1_hi_idx_r);
    end
  end

  logic             s2_v_r;
  logic [PIX_W-1:0] s2_a_r;
  logic [PIX_W-1:0] s2_dma_r;
  logic [PIX_W-1:0] s2_d_r;
  logic [PIX_W-1:0] s2_lo_r [NCH];
  logic [PIX_W-1:0] s2_hi_r [NCH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_a_r   <= a_fix_w;
    s2_dma_r <= d_fix_w - a_fix_w;
    s2_d_r   <= d_fix_w;
    for (int c = 0; c < NCH; c++) begin
      s2_lo_r[c] <= lo_c_w[c];
      s2_hi_r[c] <= hi_c_w[c];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: numerator lo*(d-a) + hi*a, fits 16 bits (at most 255*d).
  // Loads divider stage 0: remainder = top byte, low byte shifts in.
  // ---------------------------------------------------------------------
  logic             dv_v_r   [DIV_STEPS+1];
  logic [PIX_W-1:0] dv_d_r   [DIV_STEPS+1];
  logic [PIX_W-1:0] dv_rem_r [DIV_STEPS+1][NCH];
  logic [PIX_W-1:0] dv_low_r [DIV_STEPS+1][NCH];
  logic [PIX_W-1:0] dv_q_r   [DIV_STEPS+1][NCH];

  logic [2*PIX_W-1:0] num_w [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      num_w[c] = (2*PIX_W)'(s2_lo_r[c]) * (2*PIX_W)'(s2_dma_r)
               + (2*PIX_W)'(s2_hi_r[c]) * (2*PIX_W)'(s2_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_d_r[0] <= s2_d_r;
    for (int c = 0; c < NCH; c++) begin
      dv_rem_r[0][c] <= num_w[c][2*PIX_W-1:PIX_W];
      dv_low_r[0][c] <= num_w[c][PIX_W-1:0];
      dv_q_r[0][c]   <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: restoring, one quotient bit per stage. Top byte of the
  // numerator is below d, so the remainder always fits in 8 bits and the
  // quotient in 8 bits.
  // ---------------------------------------------------------------------
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [PIX_W:0]   trial_w [NCH];
    logic             ge_w    [NCH];
    logic [PIX_W:0]   diff_w  [NCH];

    always_comb begin
      for (int c = 0; c < NCH; c++) begin
        trial_w[c] = {dv_rem_r[j-1][c], dv_low_r[j-1][c][PIX_W-1]};
        ge_w[c]    = (trial_w[c] >= {1'b0, dv_d_r[j-1]});
        diff_w[c]  = trial_w[c] - {1'b0, dv_d_r[j-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      dv_d_r[j] <= dv_d_r[j-1];
      for (int c = 0; c < NCH; c++) begin
        dv_rem_r[j][c] <= ge_w[c] ? diff_w[c][PIX_W-1:0] : trial_w[c][PIX_W-1:0];
        dv_low_r[j][c] <= {dv_low_r[j-1][c][PIX_W-2:0], 1'b0};
        dv_q_r[j][c]   <= {dv_q_r[j-1][c][PIX_W-2:0], ge_w[c]};
      end
    end
  end

  assign out_valid = dv_v_r[DIV_STEPS];
  assign out_red   = dv_q_r[DIV_STEPS][0];
  assign out_green = dv_q_r[DIV_STEPS][1];
  assign out_blue  = dv_q_r[DIV_STEPS][2];

endmodule

`default_nettype wire

/* hw/rtl/gcgm_checker.sv */
// Port-level checker for the gradient map, bound to the top level.
`default_nettype none

module gcgm_checker
  import gcgm_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // Every accepted transaction yields a strobe after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted transaction produced no result");

  // No strobe without a matching accepted transaction.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LAT !out_valid)
    else $error("result strobe without accepted transaction");

  // Reset flushes everything in flight.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind gray_to_color_gradient_map gcgm_checker u_gcgm_checker (.*);

`default_nettype wire

/* tb/gray_to_color_gradient_map_test.sv */
// Self-checking testbench for the gray-to-color gradient map.
`timescale 1ns / 1ps

module gray_to_color_gradient_map_test;
  import gcgm_pkg::*;

  localparam int MAP_STOPS    = 8;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 400;   // cycles without any transaction
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int DIRECTED_ROWS = 24;

  // Register indexes the block does not decode; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  // Named register settings used by the directed part.
  typedef enum int {
    PRE_RESET,       // untouched reset map: black to white
    PRE_CUT4,        // cut mode, four ascending stops
    PRE_GRAD8,       // gradient, all eight stops, extreme red and green
    PRE_COUNT_BIG,   // stop count above the maximum, clamped
    PRE_COUNT_ZERO,  // stop count zero, upper data bits set
    PRE_COUNT_ONE,   // stop count one
    PRE_ODD_ORDER,   // first level not zero, levels out of order
    PRE_ODD_GAP      // first two levels equal
  } preset_t;

  typedef struct {
    preset_t          preset;
    logic [PIX_W-1:0] pix;
    logic             typed;   // want holds a hand-written expectation
    rgb_t             want;
  } directed_row_t;

  // Directed stimulus. Typed rows are read straight off the register values;
  // all others go through the predictor.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{PRE_RESET,      8'h00, 1'b1, 24'h000000},
    '{PRE_RESET,      8'hFF, 1'b1, 24'hFFFFFF},
    '{PRE_RESET,      8'h80, 1'b1, 24'h808080},
    '{PRE_RESET,      8'h01, 1'b1, 24'h010101},
    '{PRE_CUT4,       8'h00, 1'b0, 24'h000000},
    '{PRE_CUT4,       8'h40, 1'b0, 24'h000000},
    '{PRE_CUT4,       8'h41, 1'b0, 24'h000000},
    '{PRE_CUT4,       8'hFF, 1'b0, 24'h000000},
    '{PRE_GRAD8,      8'h00, 1'b0, 24'h000000},
    '{PRE_GRAD8,      8'h25, 1'b0, 24'h000000},
    '{PRE_GRAD8,      8'hFE, 1'b0, 24'h000000},
    '{PRE_GRAD8,      8'hFF, 1'b0, 24'h000000},
    '{PRE_COUNT_BIG,  8'hEA, 1'b0, 24'h000000},
    '{PRE_COUNT_BIG,  8'hFF, 1'b0, 24'h000000},
    '{PRE_COUNT_ZERO, 8'h00, 1'b1, 24'h5AC311},
    '{PRE_COUNT_ZERO, 8'hFF, 1'b1, 24'h5AC311},
    '{PRE_COUNT_ONE,  8'h7B, 1'b1, 24'h5AC311},
    '{PRE_ODD_ORDER,  8'h00, 1'b0, 24'h000000},
    '{PRE_ODD_ORDER,  8'h90, 1'b0, 24'h000000},
    '{PRE_ODD_ORDER,  8'hC0, 1'b0, 24'h000000},
    '{PRE_ODD_ORDER,  8'hFF, 1'b0, 24'h000000},
    '{PRE_ODD_GAP,    8'h10, 1'b0, 24'h000000},
    '{PRE_ODD_GAP,    8'h50, 1'b0, 24'h000000},
    '{PRE_ODD_GAP,    8'hA0, 1'b0, 24'h000000}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     in_gray_level = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;

  // Shadow copy of the color map registers, starting at their reset values.
  mode_t       map_mode   = MODE_GRADIENT;
  logic [3:0]  map_count  = 4'd2;
  logic [63:0] map_levels = 64'hFF00;
  logic [63:0] map_red    = 64'hFF00;
  logic [63:0] map_green  = 64'hFF00;
  logic [63:0] map_blue   = 64'hFF00;

  rgb_t expected_colors [$];
  int   mismatches  = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  gray_to_color_gradient_map #(
    .MAX_STOPS(MAP_STOPS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_gray_level(in_gray_level),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  // ---------------------------------------------------------------------------
  // Color predictor
  // ---------------------------------------------------------------------------

  function automatic logic [PIX_W-1:0] lane(input logic [63:0] pk, input int unsigned idx);
    return pk[(idx % 8) * 8 +: 8];
  endfunction

  // (lo*(d-a) + hi*a) / d, truncated; a zero gap keeps the lower color.
  function automatic logic [PIX_W-1:0] blend_channel(input logic [PIX_W-1:0] lo,
                                                     input logic [PIX_W-1:0] hi,
                                                     input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] d);
    int unsigned lo_i, hi_i, a_i, d_i;
    lo_i = lo;
    hi_i = hi;
    a_i  = a;
    d_i  = d;
    if (d_i == 0) begin
      return lo;
    end
    return PIX_W'((lo_i * (d_i - a_i) + hi_i * a_i) / d_i);
  endfunction

  function automatic rgb_t predict_color(input logic [PIX_W-1:0] pix);
    int unsigned      n, k, sel;
    logic [PIX_W-1:0] gap, offs;
    rgb_t             c;
    n = map_count;
    if (n > MAP_STOPS) n = MAP_STOPS;
    if (n < 1) n = 1;
    // first stop from index 1 whose level is not below the pixel
    k = 1;
    while (k < n && pix > lane(map_levels, k)) k++;
    if (k >= n || map_mode == MODE_CUT) begin
      sel = (k >= n) ? n - 1 : k - 1;
      c.r = lane(map_red, sel);
      c.g = lane(map_green, sel);
      c.b = lane(map_blue, sel);
    end else begin
      // 8-bit wrapping differences; offset saturates at the gap
      gap  = lane(map_levels, k) - lane(map_levels, k - 1);
      offs = pix - lane(map_levels, k - 1);
      if (offs > gap) offs = gap;
      c.r = blend_channel(lane(map_red, k - 1), lane(map_red, k), offs, gap);
      c.g = blend_channel(lane(map_green, k - 1), lane(map_green, k), offs, gap);
      c.b = blend_channel(lane(map_blue, k - 1), lane(map_blue, k), offs, gap);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered right after a rising edge, and
  // drives inputs with nonblocking assignments so the DUT sees them next edge.
  // ---------------------------------------------------------------------------

  // One config transaction; keeps cfg_we high for back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_MODE:       map_mode   = mode_t'(data[0]);
      CFG_STOP_COUNT: map_count  = data[3:0];
      CFG_LEVELS:     map_levels = data;
      CFG_RED:        map_red    = data;
      CFG_GREEN:      map_green  = data;
      CFG_BLUE:       map_blue   = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop feeding and let the pipeline empty before touching the map.
  task automatic settle();
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap(input int unsigned style);
    int unsigned roll;
    if (style == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one pixel, wait for the accepting edge, log what should come out.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input int unsigned gap,
                            input logic typed, input rgb_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_gray_level <= pix;
    do @(posedge clk); while (busy !== 1'b0);
    expected_colors.push_back(typed ? want : predict_color(pix));
  endtask

  task automatic apply_preset(input preset_t p);
    case (p)
      PRE_CUT4: begin
        write_reg(CFG_MODE, 64'h1);
        write_reg(CFG_STOP_COUNT, 64'h4);
        write_reg(CFG_LEVELS, 64'h00000000_FF804000);
        write_reg(CFG_RED,    64'h00000000_FF804010);
        write_reg(CFG_GREEN,  64'h00000000_10204080);
        write_reg(CFG_BLUE,   64'h00000000_00FF00FF);
      end
      PRE_GRAD8: begin
        write_reg(CFG_MODE, 64'h0);
        write_reg(CFG_STOP_COUNT, 64'h8);
        write_reg(CFG_LEVELS, 64'hFFE0B090_60301000);
        write_reg(CFG_RED,    64'hFF00FF00_FF00FF00);
        write_reg(CFG_GREEN,  64'h00FF00FF_00FF00FF);
        write_reg(CFG_BLUE,   64'h12345678_9ABCDEF0);
      end
      PRE_COUNT_BIG: begin
        // count 15 clamps to eight stops; top level 0xF0 leaves room above
        write_reg(CFG_STOP_COUNT, 64'hF);
        write_reg(CFG_LEVELS, 64'hF0C0A080_60402000);
        write_reg(CFG_RED,    64'h01234567_89ABCDEF);
        write_reg(CFG_GREEN,  64'hFEDCBA98_76543210);
        write_reg(CFG_BLUE,   64'hA5A5A5A5_5A5A5A5A);
      end
      PRE_COUNT_ZERO: begin
        // upper data bits set on the narrow registers must be dropped
        write_reg(CFG_MODE,       64'hFFFFFFFF_FFFFFFFE);
        write_reg(CFG_STOP_COUNT, 64'hFFFFFFFF_FFFFFFF0);
        write_reg(CFG_LEVELS, 64'h80402010_08040200);
        write_reg(CFG_RED,    64'h77777777_7777775A);
        write_reg(CFG_GREEN,  64'h77777777_777777C3);
        write_reg(CFG_BLUE,   64'h77777777_77777711);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
      end
      PRE_COUNT_ONE: begin
        write_reg(CFG_MODE, 64'h1);
        write_reg(CFG_STOP_COUNT, 64'h1);
      end
      PRE_ODD_ORDER: begin
        write_reg(CFG_MODE, 64'h0);
        write_reg(CFG_STOP_COUNT, 64'h6);
        write_reg(CFG_LEVELS, 64'h000010C0_C0408020);
        write_reg(CFG_RED,    64'h00001122_33445566);
        write_reg(CFG_GREEN,  64'h0000F0E0_D0C0B0A0);
        write_reg(CFG_BLUE,   64'h00000FFF_00FF0F0F);
      end
      PRE_ODD_GAP: begin
        write_reg(CFG_STOP_COUNT, 64'h3);
        write_reg(CFG_LEVELS, 64'h00000000_00F05050);
      end
      default: ;
    endcase
    end_writes();
  endtask

  // Random map for one phase. The first two phases pin every register to
  // all zeros and all ones; the rest are mostly well-formed maps.
  task automatic randomize_map(input int phase);
    logic [7:0]  lv [8];
    logic [7:0]  tmp;
    logic [63:0] packed_lv;
    int unsigned style;
    if (phase == 0) begin
      write_reg(CFG_MODE, '0);
      write_reg(CFG_STOP_COUNT, '0);
      write_reg(CFG_LEVELS, '0);
      write_reg(CFG_RED, '0);
      write_reg(CFG_GREEN, '0);
      write_reg(CFG_BLUE, '0);
    end else if (phase == 1) begin
      write_reg(CFG_MODE, '1);
      write_reg(CFG_STOP_COUNT, '1);
      write_reg(CFG_LEVELS, '1);
      write_reg(CFG_RED, '1);
      write_reg(CFG_GREEN, '1);
      write_reg(CFG_BLUE, '1);
    end else begin
      write_reg(CFG_MODE, {$urandom, $urandom});
      if ($urandom_range(0, 9) < 8) begin
        write_reg(CFG_STOP_COUNT, 64'($urandom_range(2, MAP_STOPS)));
      end else begin
        write_reg(CFG_STOP_COUNT, {$urandom, $urandom});
      end
      style = $urandom_range(0, 4);
      if (style == 0) begin
        packed_lv = {$urandom, $urandom};
      end else begin
        // sorted levels, with the odd repeated level for zero gaps
        for (int i = 0; i < 8; i++) begin
          lv[i] = (i > 0 && $urandom_range(0, 5) == 0) ? lv[i-1] : 8'($urandom);
        end
        for (int i = 1; i < 8; i++) begin
          for (int j = i; j > 0 && lv[j-1] > lv[j]; j--) begin
            tmp     = lv[j];
            lv[j]   = lv[j-1];
            lv[j-1] = tmp;
          end
        end
        if (style != 4) lv[0] = 8'h00;
        for (int i = 0; i < 8; i++) packed_lv[i*8 +: 8] = lv[i];
      end
      write_reg(CFG_LEVELS, packed_lv);
      write_reg(CFG_RED,   {$urandom, $urandom});
      write_reg(CFG_GREEN, {$urandom, $urandom});
      write_reg(CFG_BLUE,  {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
      end
    end
    end_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed result is matched against the oldest
  // expectation. Sampled at the edge, so pre-edge output values are seen.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input rgb_t want, input rgb_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
               what, want.r, want.g, want.b, got.r, got.g, got.b);
    end
  endtask

  always @(posedge clk) begin
    rgb_t want, got;
    if (rst_n && out_valid === 1'b1) begin
      got = '{r: out_red, g: out_green, b: out_blue};
      if (expected_colors.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = expected_colors.pop_front();
        if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
          note_mismatch("color", want, got);
        end
      end
    end
  end

  // Watchdog: any accepted pixel or strobed result counts as progress.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    preset_t          cur_preset;
    int unsigned      gap_style;
    logic [PIX_W-1:0] pix;
    int unsigned      roll;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: first rows run on the reset map with no writes at all.
    cur_preset = PRE_RESET;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].preset != cur_preset) begin
        settle();
        apply_preset(directed_rows[i].preset);
        cur_preset = directed_rows[i].preset;
      end
      send_pixel(directed_rows[i].pix, pick_gap(1), directed_rows[i].typed,
                 directed_rows[i].want);
    end

    // Random part: a fresh map per phase, then a burst of pixels on it.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      randomize_map(phase);
      gap_style = (phase % 4 == 0) ? 0 : 1;  // some phases stream with no gaps
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (roll < 4) begin
          // land on or next to a stop level, where segment selection flips
          pix = lane(map_levels, $urandom_range(0, 7)) + 8'($urandom_range(0, 2)) - 8'd1;
        end else begin
          pix = 8'($urandom);
        end
        send_pixel(pix, pick_gap(gap_style), 1'b0, '0);
      end
    end

    // Drain: the watchdog bounds the wait if results stop coming.
    settle();
    repeat (PIPE_LAT * 2) @(posedge clk);
    mismatches += expected_colors.size();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* gray_to_color_gradient_map.f */
hw/rtl/gcgm_pkg.sv
hw/rtl/gray_to_color_gradient_map.sv
hw/rtl/gcgm_checker.sv
tb/gray_to_color_gradient_map_test.sv
